/* rtl/core/fba_pkg.sv */
// Package for the frame bitmap allocator: field widths, operation and status
// codes, the command and status structs between controller and datapath and a helper.
// Depends on nothing.
`default_nettype none

package fba_pkg;

  localparam int WORD_W      = 64;
  localparam int BIT_W       = 6;
  localparam int FRAME_SHIFT = 12;
  localparam int CFG_W       = 13;
  localparam int ADDR_W      = 32;
  localparam int IDX_W       = ADDR_W - FRAME_SHIFT;
  localparam int FADDR_W     = 24;
  localparam int OP_W        = 2;
  localparam int ST_W        = 2;

  localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE    = 2'd1;
  localparam logic [OP_W-1:0] OP_RESERVE = 2'd2;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic            load_in;
    logic            clr_wr;
    logic            rd_first;
    logic            rd_rmw;
    logic            rd_next;
    logic            scan_wr;
    logic            rmw_wr;
    logic            res_en;
    logic            res_hit;
    logic [ST_W-1:0] res_status;
    logic            load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            in_range;
    logic            limit_zero;
    logic            scan_hit;
    logic            scan_last;
    logic            clr_last;
  } dp_stat_t;

  function automatic logic [BIT_W-1:0] onehot_index(input logic [WORD_W-1:0] onehot);
    logic [BIT_W-1:0] res;
    res = '0;
    for (int k = 0; k < WORD_W; k++) begin
      if (onehot[k]) begin
        res = res | BIT_W'(k);
      end
    end
    return res;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/frame_bitmap_allocator.sv */
// Frame bitmap allocator, first fit, one bit per 4 KiB frame.
// The input channel carries an opcode (alloc, free, reserve) and a byte
// address; the output channel returns one beat per input beat with the
// allocated frame address and a status code. Both channels use valid/stall.
// The frame_count register is written through cfg_we/cfg_wdata; the user
// writes it only while idle, which the block itself does not enforce. The
// bitmap lives in a RAM of 64-bit words; alloc reads one word per cycle
// and takes the lowest clear bit below the frame count. In range, free and
// reserve read and rewrite one bitmap word; failed range checks, unused
// opcodes and alloc at a zero frame count return a status without touching
// the bitmap; other allocs scan words in order until a clear bit is found
// or the last word is read, at most ceil(NUM_FRAMES / 64) words, 64 at the
// default size. One item is processed at a time: an item holds the block
// until its result is in the output register, and the next beat is
// accepted as soon as it is there, even while the receiver stalls it.
// After reset a clearing pass marks every frame used, one word per cycle,
// with in_stall high. A stalled output beat holds until taken; the block
// then waits with its next result and keeps in_stall high.
// Depends on fba_pkg, fba_ctrl, fba_datapath and fba_ram.
`default_nettype none

module frame_bitmap_allocator #(
  parameter int NUM_FRAMES = 4096
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [fba_pkg::OP_W-1:0]     opcode,
  input  logic [fba_pkg::ADDR_W-1:0]   address,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [fba_pkg::FADDR_W-1:0]  frame_address,
  output logic [fba_pkg::ST_W-1:0]     status,
  input  logic                         cfg_we,
  input  logic [fba_pkg::CFG_W-1:0]    cfg_wdata
);

  localparam logic [fba_pkg::CFG_W-1:0] FRAME_COUNT_RESET = 13'd4096;

  logic [fba_pkg::CFG_W-1:0] frame_count;
  fba_pkg::dp_cmd_t          cmd;
  fba_pkg::dp_stat_t         stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count <= FRAME_COUNT_RESET;
    end else if (cfg_we) begin
      frame_count <= cfg_wdata;
    end
  end

  fba_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  fba_datapath #(
    .NUM_FRAMES (NUM_FRAMES)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .frame_count   (frame_count),
    .opcode        (opcode),
    .address       (address),
    .cmd           (cmd),
    .stat          (stat),
    .frame_address (frame_address),
    .status        (status)
  );

endmodule

`default_nettype wire

/* rtl/core/fba_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
`default_nettype none

module fba_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* rtl/core/fba_datapath.sv */
// Datapath of the frame bitmap allocator: bitmap RAM, scan pointer, search
// logic, read-modify-write logic and result registers.
// Depends on fba_pkg and fba_ram.
`default_nettype none

module fba_datapath #(
  parameter int NUM_FRAMES = 4096
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [fba_pkg::CFG_W-1:0]    frame_count,
  input  logic [fba_pkg::OP_W-1:0]     opcode,
  input  logic [fba_pkg::ADDR_W-1:0]   address,
  input  fba_pkg::dp_cmd_t             cmd,
  output fba_pkg::dp_stat_t            stat,
  output logic [fba_pkg::FADDR_W-1:0]  frame_address,
  output logic [fba_pkg::ST_W-1:0]     status
);

  localparam int WORD_W = fba_pkg::WORD_W;
  localparam int BIT_W  = fba_pkg::BIT_W;
  localparam int WORDS  = (NUM_FRAMES + WORD_W - 1) / WORD_W;
  localparam int AW     = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int LIM_W  = $clog2(NUM_FRAMES + 1);
  localparam int CMP_W  = (LIM_W > fba_pkg::CFG_W) ? LIM_W : fba_pkg::CFG_W;
  localparam int IC_W   = (LIM_W > fba_pkg::IDX_W) ? LIM_W : fba_pkg::IDX_W;
  localparam logic [BIT_W-1:0] TOP_BIT = BIT_W'(WORD_W - 1);

  logic [fba_pkg::OP_W-1:0]    op_q;
  logic [fba_pkg::IDX_W-1:0]   idx_q;
  logic [LIM_W-1:0]            limit_q;
  logic [AW-1:0]               scan_ptr;
  logic [fba_pkg::FADDR_W-1:0] res_faddr;
  logic [fba_pkg::ST_W-1:0]    res_status;

  logic [CMP_W-1:0]            fc_ext;
  logic [CMP_W-1:0]            nf_ext;
  logic [CMP_W-1:0]            lim_sel;
  logic [LIM_W-1:0]            limit_m1;
  logic [AW-1:0]               last_word;
  logic [BIT_W-1:0]            last_bit;
  logic [AW-1:0]               rmw_word;
  logic [BIT_W-1:0]            rmw_bit;
  logic [WORD_W-1:0]           rdata;
  logic [WORD_W-1:0]           mask;
  logic [WORD_W-1:0]           free_bits;
  logic [WORD_W-1:0]           low_bit;
  logic [BIT_W-1:0]            hit_pos;
  logic [31:0]                 hit_index;
  logic [fba_pkg::FADDR_W-1:0] hit_faddr;
  logic [WORD_W-1:0]           bit_sel;
  logic [WORD_W-1:0]           rmw_data;
  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  logic [WORD_W-1:0]           ram_wdata;
  logic [AW-1:0]               ram_raddr;

  assign fc_ext  = CMP_W'(frame_count);
  assign nf_ext  = CMP_W'(NUM_FRAMES);
  assign lim_sel = (fc_ext > nf_ext) ? nf_ext : fc_ext;

  assign limit_m1  = limit_q - LIM_W'(1);
  assign last_word = AW'(limit_m1 >> BIT_W);
  assign last_bit  = BIT_W'(limit_m1);
  assign rmw_word  = AW'(idx_q >> BIT_W);
  assign rmw_bit   = idx_q[BIT_W-1:0];

  assign mask      = (scan_ptr == last_word) ? ({WORD_W{1'b1}} >> (TOP_BIT - last_bit))
                                             : {WORD_W{1'b1}};
  assign free_bits = ~rdata & mask;
  assign low_bit   = free_bits & (~free_bits + WORD_W'(1));
  assign hit_pos   = fba_pkg::onehot_index(low_bit);
  assign hit_index = (32'(scan_ptr) << BIT_W) | 32'(hit_pos);
  assign hit_faddr = fba_pkg::FADDR_W'(hit_index << fba_pkg::FRAME_SHIFT);

  assign bit_sel  = WORD_W'(1) << rmw_bit;
  assign rmw_data = (op_q == fba_pkg::OP_FREE) ? (rdata & ~bit_sel) : (rdata | bit_sel);

  assign stat.op         = op_q;
  assign stat.in_range   = IC_W'(idx_q) < IC_W'(limit_q);
  assign stat.limit_zero = (limit_q == '0);
  assign stat.scan_hit   = |free_bits;
  assign stat.scan_last  = (scan_ptr == last_word);
  assign stat.clr_last   = (scan_ptr == AW'(WORDS - 1));

  assign ram_we    = cmd.clr_wr | cmd.scan_wr | cmd.rmw_wr;
  assign ram_waddr = cmd.rmw_wr ? rmw_word : scan_ptr;

  always_comb begin
    priority if (cmd.clr_wr) begin
      ram_wdata = {WORD_W{1'b1}};
    end else if (cmd.scan_wr) begin
      ram_wdata = rdata | low_bit;
    end else begin
      ram_wdata = rmw_data;
    end
  end

  always_comb begin
    priority if (cmd.rd_rmw) begin
      ram_raddr = rmw_word;
    end else if (cmd.rd_next) begin
      ram_raddr = AW'(scan_ptr + AW'(1));
    end else begin
      ram_raddr = '0;
    end
  end

  fba_ram #(
    .WIDTH (WORD_W),
    .DEPTH (WORDS)
  ) u_map_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_ptr <= '0;
    end else if (cmd.rd_first) begin
      scan_ptr <= '0;
    end else if (cmd.clr_wr || cmd.rd_next) begin
      scan_ptr <= AW'(scan_ptr + AW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_q    <= opcode;
      idx_q   <= address[fba_pkg::ADDR_W-1:fba_pkg::FRAME_SHIFT];
      limit_q <= LIM_W'(lim_sel);
    end
    if (cmd.res_en) begin
      res_faddr  <= cmd.res_hit ? hit_faddr : '0;
      res_status <= cmd.res_status;
    end
    if (cmd.load_out) begin
      frame_address <= res_faddr;
      status        <= res_status;
    end
  end

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_wr |-> (scan_ptr <= last_word) && !stat.limit_zero)
    else $error("bitmap write outside the searched words");

endmodule

`default_nettype wire

/* rtl/core/fba_ctrl.sv */
// Controller of the frame bitmap allocator: clearing pass, operation decode,
// word scan sequencing and the output handshake.
// Depends on fba_pkg.
`default_nettype none

module fba_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  fba_pkg::dp_stat_t stat,
  output fba_pkg::dp_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_RMW,
    S_FINISH
  } state_t;

  state_t state;
  state_t state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (stat.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (stat.op)
          fba_pkg::OP_ALLOC: begin
            if (stat.limit_zero) begin
              cmd.res_en     = 1'b1;
              cmd.res_status = fba_pkg::ST_FULL;
              state_next     = S_FINISH;
            end else begin
              cmd.rd_first = 1'b1;
              state_next   = S_SCAN;
            end
          end
          fba_pkg::OP_FREE, fba_pkg::OP_RESERVE: begin
            if (stat.in_range) begin
              cmd.rd_rmw = 1'b1;
              state_next = S_RMW;
            end else begin
              cmd.res_en     = 1'b1;
              cmd.res_status = fba_pkg::ST_RANGE;
              state_next     = S_FINISH;
            end
          end
          default: begin
            cmd.res_en     = 1'b1;
            cmd.res_status = fba_pkg::ST_OK;
            state_next     = S_FINISH;
          end
        endcase
      end
      S_SCAN: begin
        priority if (stat.scan_hit) begin
          cmd.scan_wr    = 1'b1;
          cmd.res_en     = 1'b1;
          cmd.res_hit    = 1'b1;
          cmd.res_status = fba_pkg::ST_OK;
          state_next     = S_FINISH;
        end else if (stat.scan_last) begin
          cmd.res_en     = 1'b1;
          cmd.res_status = fba_pkg::ST_FULL;
          state_next     = S_FINISH;
        end else begin
          cmd.rd_next = 1'b1;
        end
      end
      S_RMW: begin
        cmd.rmw_wr     = 1'b1;
        cmd.res_en     = 1'b1;
        cmd.res_status = fba_pkg::ST_OK;
        state_next     = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid || !out_stall) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_one_writer: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.clr_wr, cmd.scan_wr, cmd.rmw_wr}))
    else $error("more than one bitmap write in a cycle");

  a_load_free_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || !out_stall))
    else $error("result register overwritten while held");

endmodule

`default_nettype wire
